// ===== src/pha_pkg.sv =====
`default_nettype none

package pha_pkg;

  // Field widths fixed by the packet format and register map.
  localparam int PortW     = 16;
  localparam int HeaderW   = 64;
  localparam int TimeW     = 38;
  localparam int ChanW     = 10;
  localparam int AntW      = 9;
  localparam int SampW     = 13;
  localparam int CountW    = 11;
  localparam int SeqW      = 16;
  localparam int OffW      = 30;
  localparam int ProdW     = ChanW + AntW;
  localparam int FullProdW = ProdW + SampW;
  localparam int ActW      = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  // Header bit positions.
  localparam int TimeLsb = 26;
  localparam int ChanLsb = 16;

  // Count saturation and default packet limit.
  localparam logic [CountW-1:0] CountMax = '1;
  localparam int MaxPacketsDef = 1024;

  // Reset values of the configuration registers.
  localparam logic [PortW-1:0]  ListenPortRst = '0;
  localparam logic [AntW-1:0]   AntennasRst   = AntW'(1);
  localparam logic [SampW-1:0]  SamplesRst    = SampW'(4096);
  localparam logic [CountW-1:0] PktsPerHeapRst = CountW'(1024);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgListenPort = 2'd0,
    CfgAntennas   = 2'd1,
    CfgSamples    = 2'd2,
    CfgPktsPerHeap = 2'd3
  } cfg_idx_e;

  // Per-packet action codes.
  typedef enum logic [ActW-1:0] {
    ActWrongPort  = 2'd0,
    ActLate       = 2'd1,
    ActStored     = 2'd2,
    ActStoredLoss = 2'd3
  } action_e;

  // Controller states.
  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StMul1   = 4'b0010,
    StMul2   = 4'b0100,
    StCommit = 4'b1000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/pha_ctrl.sv =====
`default_nettype none

module pha_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output pha_pkg::cmd_t      cmd_o
);

  pha_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  // The output register can take a new beat when empty or being drained.
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      pha_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = pha_pkg::StMul1;
        end
      end
      pha_pkg::StMul1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = pha_pkg::StMul2;
      end
      pha_pkg::StMul2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = pha_pkg::StCommit;
      end
      pha_pkg::StCommit: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = pha_pkg::StIdle;
        end
      end
      default: begin
        state_d = pha_pkg::StIdle;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pha_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == pha_pkg::StIdle);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/pha_datapath.sv =====
`default_nettype none

module pha_datapath #(
  parameter int MaxPackets = pha_pkg::MaxPacketsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pha_pkg::cmd_t                 cmd_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [pha_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pha_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic [pha_pkg::PortW-1:0]     dest_port_i,
  input  wire logic [pha_pkg::HeaderW-1:0]   header_word_i,
  output logic [pha_pkg::ActW-1:0]           action_o,
  output logic [pha_pkg::ChanW-1:0]          reordered_channel_o,
  output logic [pha_pkg::OffW-1:0]           write_offset_o,
  output logic [pha_pkg::SeqW-1:0]           write_heap_o,
  output logic                               heap_closed_o,
  output logic [pha_pkg::TimeW-1:0]          closed_time_o,
  output logic [pha_pkg::CountW-1:0]         closed_count_o,
  output logic                               closed_short_o
);

  // Packet target limit: MaxPackets capped at the count ceiling.
  localparam int TargetLimInt = (MaxPackets > int'(pha_pkg::CountMax)) ?
                                int'(pha_pkg::CountMax) : MaxPackets;
  localparam logic [pha_pkg::CountW-1:0] TargetLim = pha_pkg::CountW'(TargetLimInt);

  // Configuration registers.
  logic [pha_pkg::PortW-1:0]  listen_q;
  logic [pha_pkg::AntW-1:0]   antennas_q;
  logic [pha_pkg::SampW-1:0]  samples_q;
  logic [pha_pkg::CountW-1:0] pkts_q;

  // Heap tracking state.
  logic [pha_pkg::TimeW-1:0]  open_q, open_d;
  logic [pha_pkg::CountW-1:0] count_q, count_d;
  logic [pha_pkg::SeqW-1:0]   seq_q, seq_d;

  // Captured packet and offset pipeline.
  logic [pha_pkg::PortW-1:0]  port_q;
  logic [pha_pkg::TimeW-1:0]  time_q;
  logic [pha_pkg::ChanW-1:0]  chan_q;
  logic [pha_pkg::ProdW-1:0]  prod_q;
  logic [pha_pkg::OffW-1:0]   offset_q;
  logic [pha_pkg::ChanW-1:0]  raw_chan;
  logic [pha_pkg::FullProdW-1:0] full_prod;

  // Result for the output register.
  logic [pha_pkg::ActW-1:0]   act_d;
  logic [pha_pkg::ChanW-1:0]  rchan_d;
  logic [pha_pkg::OffW-1:0]   off_d;
  logic [pha_pkg::SeqW-1:0]   heap_d;
  logic                       closed_d;
  logic [pha_pkg::TimeW-1:0]  ctime_d;
  logic [pha_pkg::CountW-1:0] ccount_d;
  logic                       cshort_d;

  logic [pha_pkg::TimeW-1:0]  eff_time;
  logic [pha_pkg::CountW-1:0] count_inc;
  logic [pha_pkg::CountW-1:0] target;
  logic [pha_pkg::SeqW-1:0]   seq_inc;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q   <= pha_pkg::ListenPortRst;
      antennas_q <= pha_pkg::AntennasRst;
      samples_q  <= pha_pkg::SamplesRst;
      pkts_q     <= pha_pkg::PktsPerHeapRst;
    end else if (cfg_we_i) begin
      case (pha_pkg::cfg_idx_e'(cfg_index_i))
        pha_pkg::CfgListenPort:  listen_q   <= cfg_data_i;
        pha_pkg::CfgAntennas:    antennas_q <= cfg_data_i[pha_pkg::AntW-1:0];
        pha_pkg::CfgSamples:     samples_q  <= cfg_data_i[pha_pkg::SampW-1:0];
        pha_pkg::CfgPktsPerHeap: pkts_q     <= cfg_data_i[pha_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // De-interleave: even channels to the low half, odd to the high half.
  assign raw_chan  = header_word_i[pha_pkg::ChanLsb +: pha_pkg::ChanW];
  assign full_prod = prod_q * samples_q;

  // Capture the beat, then build the offset in two multiply steps.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      port_q <= dest_port_i;
      time_q <= header_word_i[pha_pkg::TimeLsb +: pha_pkg::TimeW];
      chan_q <= {raw_chan[0], raw_chan[pha_pkg::ChanW-1:1]};
    end
    if (cmd_i.mul1) begin
      prod_q <= chan_q * antennas_q;
    end
    if (cmd_i.mul2) begin
      offset_q <= full_prod[pha_pkg::OffW-1:0];
    end
  end

  // Heap decision.
  assign eff_time  = (open_q == '0) ? time_q : open_q;
  assign count_inc = (count_q == pha_pkg::CountMax) ? count_q : count_q + 1'b1;
  assign seq_inc   = seq_q + 1'b1;

  always_comb begin
    if (pkts_q == '0) begin
      target = pha_pkg::CountW'(1);
    end else if (pkts_q > TargetLim) begin
      target = TargetLim;
    end else begin
      target = pkts_q;
    end
  end

  always_comb begin
    act_d    = pha_pkg::ActWrongPort;
    rchan_d  = '0;
    off_d    = '0;
    heap_d   = '0;
    closed_d = 1'b0;
    ctime_d  = '0;
    ccount_d = '0;
    cshort_d = 1'b0;
    open_d   = open_q;
    count_d  = count_q;
    seq_d    = seq_q;
    if (port_q == listen_q) begin
      rchan_d = chan_q;
      open_d  = eff_time;
      if (time_q != eff_time) begin
        if (time_q < eff_time) begin
          act_d = pha_pkg::ActLate;
        end else begin
          // A newer time closes the open heap as short.
          act_d    = pha_pkg::ActStoredLoss;
          closed_d = 1'b1;
          ctime_d  = eff_time;
          ccount_d = count_q;
          cshort_d = 1'b1;
          seq_d    = seq_inc;
          off_d    = offset_q;
          heap_d   = seq_inc;
          count_d  = pha_pkg::CountW'(1);
          open_d   = time_q;
        end
      end else begin
        act_d   = pha_pkg::ActStored;
        off_d   = offset_q;
        heap_d  = seq_q;
        count_d = count_inc;
        // The last expected packet closes the heap as complete.
        if (count_inc == target) begin
          closed_d = 1'b1;
          ctime_d  = eff_time;
          ccount_d = count_inc;
          seq_d    = seq_inc;
          open_d   = '0;
          count_d  = '0;
        end
      end
    end
  end

  // Heap state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= '0;
      count_q <= '0;
      seq_q   <= '0;
    end else if (cmd_i.commit) begin
      open_q  <= open_d;
      count_q <= count_d;
      seq_q   <= seq_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      action_o            <= act_d;
      reordered_channel_o <= rchan_d;
      write_offset_o      <= off_d;
      write_heap_o        <= heap_d;
      heap_closed_o       <= closed_d;
      closed_time_o       <= ctime_d;
      closed_count_o      <= ccount_d;
      closed_short_o      <= cshort_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/packet_heap_assembler.sv =====
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid_i/in_ready_o   dest_port_i, header_word_i
// out      out_valid_o/out_ready_i action_o .. closed_short_o
// cfg      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each packet passes through capture, channel times antennas, times samples,
// then the heap decision that loads the output register.
// The two multiplies of the offset are separate steps; the next packet is taken
// while the previous result still waits in the output register.
// Reset clears the heap time, count and sequence and loads register defaults.
// A stalled output holds the decision step until the output register drains.
module packet_heap_assembler #(
  parameter int MaxPackets = pha_pkg::MaxPacketsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [pha_pkg::PortW-1:0]     dest_port_i,
  input  wire logic [pha_pkg::HeaderW-1:0]   header_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [pha_pkg::ActW-1:0]           action_o,
  output logic [pha_pkg::ChanW-1:0]          reordered_channel_o,
  output logic [pha_pkg::OffW-1:0]           write_offset_o,
  output logic [pha_pkg::SeqW-1:0]           write_heap_o,
  output logic                               heap_closed_o,
  output logic [pha_pkg::TimeW-1:0]          closed_time_o,
  output logic [pha_pkg::CountW-1:0]         closed_count_o,
  output logic                               closed_short_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pha_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pha_pkg::CfgDataW-1:0]  cfg_data_i
);

  pha_pkg::cmd_t cmd;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  pha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  pha_datapath #(
    .MaxPackets (MaxPackets)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .dest_port_i         (dest_port_i),
    .header_word_i       (header_word_i),
    .action_o            (action_o),
    .reordered_channel_o (reordered_channel_o),
    .write_offset_o      (write_offset_o),
    .write_heap_o        (write_heap_o),
    .heap_closed_o       (heap_closed_o),
    .closed_time_o       (closed_time_o),
    .closed_count_o      (closed_count_o),
    .closed_short_o      (closed_short_o)
  );

  // A wrong-port beat carries no heap information.
  a_wrong_port_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == pha_pkg::ActWrongPort)
    |-> !heap_closed_o && (reordered_channel_o == '0) && (write_heap_o == '0))
    else $error("wrong-port result carries data");

  // A late packet neither writes nor closes a heap.
  a_late_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == pha_pkg::ActLate)
    |-> !heap_closed_o && (write_offset_o == '0) && (write_heap_o == '0))
    else $error("late result carries write or close data");

  // A store after loss always reports a short closed heap.
  a_loss_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == pha_pkg::ActStoredLoss)
    |-> heap_closed_o && closed_short_o)
    else $error("store after loss without short close");

  // One packet at a time: an accepted beat blocks the next cycle's input.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on back-to-back cycles");

endmodule

`default_nettype wire

// ===== sim/pha_checker.sv =====
module pha_checker #(
  parameter int MaxPackets = pha_pkg::MaxPacketsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [pha_pkg::PortW-1:0]     dest_port_i,
  input  logic [pha_pkg::HeaderW-1:0]   header_word_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [pha_pkg::ActW-1:0]      action_i,
  input  logic [pha_pkg::ChanW-1:0]     reordered_channel_i,
  input  logic [pha_pkg::OffW-1:0]      write_offset_i,
  input  logic [pha_pkg::SeqW-1:0]      write_heap_i,
  input  logic                          heap_closed_i,
  input  logic [pha_pkg::TimeW-1:0]     closed_time_i,
  input  logic [pha_pkg::CountW-1:0]    closed_count_i,
  input  logic                          closed_short_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [pha_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pha_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                            n_fail_o,
  output int                            n_pending_o,
  output int                            n_closed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // What the block should report for one packet.
  typedef struct packed {
    pha_pkg::action_e             action;
    logic [pha_pkg::ChanW-1:0]    chan;
    logic [pha_pkg::OffW-1:0]     offset;
    logic [pha_pkg::SeqW-1:0]     heap;
    logic                         closed;
    logic [pha_pkg::TimeW-1:0]    ctime;
    logic [pha_pkg::CountW-1:0]   ccount;
    logic                         cshort;
  } decision_t;

  decision_t decision_q[$];

  // Shadow copy of the registers and of the heap tracking state.
  logic [pha_pkg::PortW-1:0]  listen_port;
  logic [pha_pkg::AntW-1:0]   antennas;
  logic [pha_pkg::SampW-1:0]  samples;
  logic [pha_pkg::CountW-1:0] pkts_per_heap;
  logic [pha_pkg::TimeW-1:0]  open_time;
  logic [pha_pkg::CountW-1:0] pkt_count;
  logic [pha_pkg::SeqW-1:0]   heap_seq;

  int fails;
  int closed_heaps;

  assign n_fail_o   = fails;
  assign n_closed_o = closed_heaps;

  // Packets that complete a heap, after clamping the register.
  function automatic int heap_target();
    int lim;
    int tgt;
    lim = MaxPackets;
    if (lim > int'(pha_pkg::CountMax)) lim = int'(pha_pkg::CountMax);
    if (lim < 1) lim = 1;
    tgt = int'(pkts_per_heap);
    if (tgt < 1) tgt = 1;
    if (tgt > lim) tgt = lim;
    return tgt;
  endfunction

  // Works out the decision for one packet and advances the heap state.
  function automatic decision_t assemble_packet(
      input logic [pha_pkg::PortW-1:0] port,
      input logic [pha_pkg::HeaderW-1:0] hdr);
    decision_t                 d;
    logic [pha_pkg::TimeW-1:0] t;
    logic [pha_pkg::ChanW-1:0] raw;
    logic [pha_pkg::ChanW-1:0] ch;
    logic [63:0]               prod;
    d = '0;
    d.action = pha_pkg::ActWrongPort;
    if (port == listen_port) begin
      t   = hdr[pha_pkg::TimeLsb +: pha_pkg::TimeW];
      raw = hdr[pha_pkg::ChanLsb +: pha_pkg::ChanW];
      // Even channels fill the low half, odd channels the high half.
      ch   = raw[0] ? pha_pkg::ChanW'(512 + (raw >> 1)) : pha_pkg::ChanW'(raw >> 1);
      prod = 64'(ch) * 64'(antennas) * 64'(samples);
      d.chan = ch;
      if (open_time == '0) open_time = t;
      if (t < open_time) begin
        d.action = pha_pkg::ActLate;
      end else if (t > open_time) begin
        // A newer time closes the open heap as short.
        d.action = pha_pkg::ActStoredLoss;
        d.closed = 1'b1;
        d.ctime  = open_time;
        d.ccount = pkt_count;
        d.cshort = 1'b1;
        heap_seq = heap_seq + 1'b1;
        d.offset = prod[pha_pkg::OffW-1:0];
        d.heap   = heap_seq;
        pkt_count = pha_pkg::CountW'(1);
        open_time = t;
        closed_heaps++;
      end else begin
        d.action = pha_pkg::ActStored;
        d.offset = prod[pha_pkg::OffW-1:0];
        d.heap   = heap_seq;
        if (pkt_count != pha_pkg::CountMax) pkt_count = pkt_count + 1'b1;
        if (int'(pkt_count) == heap_target()) begin
          d.closed  = 1'b1;
          d.ctime   = open_time;
          d.ccount  = pkt_count;
          heap_seq  = heap_seq + 1'b1;
          open_time = '0;
          pkt_count = '0;
          closed_heaps++;
        end
      end
    end
    return d;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fails++;
    end
  endtask

  // Watch all three channels at each clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    decision_t d;
    if (!rst_ni) begin
      listen_port   = pha_pkg::ListenPortRst;
      antennas      = pha_pkg::AntennasRst;
      samples       = pha_pkg::SamplesRst;
      pkts_per_heap = pha_pkg::PktsPerHeapRst;
      open_time     = '0;
      pkt_count     = '0;
      heap_seq      = '0;
      decision_q.delete();
      n_pending_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (pha_pkg::cfg_idx_e'(cfg_index_i))
          pha_pkg::CfgListenPort:  listen_port   = cfg_data_i[pha_pkg::PortW-1:0];
          pha_pkg::CfgAntennas:    antennas      = cfg_data_i[pha_pkg::AntW-1:0];
          pha_pkg::CfgSamples:     samples       = cfg_data_i[pha_pkg::SampW-1:0];
          pha_pkg::CfgPktsPerHeap: pkts_per_heap = cfg_data_i[pha_pkg::CountW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (decision_q.size() == 0) begin
          $display("%0t ns: result beat with no packet outstanding, action %0d",
                   $time, action_i);
          fails++;
        end else begin
          d = decision_q.pop_front();
          check_field("action", 64'(d.action), 64'(action_i));
          check_field("reordered_channel", 64'(d.chan), 64'(reordered_channel_i));
          check_field("write_offset", 64'(d.offset), 64'(write_offset_i));
          check_field("write_heap", 64'(d.heap), 64'(write_heap_i));
          check_field("heap_closed", 64'(d.closed), 64'(heap_closed_i));
          check_field("closed_time", 64'(d.ctime), 64'(closed_time_i));
          check_field("closed_count", 64'(d.ccount), 64'(closed_count_i));
          check_field("closed_short", 64'(d.cshort), 64'(closed_short_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        decision_q.push_back(assemble_packet(dest_port_i, header_word_i));
      end
      n_pending_o <= decision_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseItems = 175;
  localparam int NumPhases  = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         in_valid_i    = 1'b0;
  logic [pha_pkg::PortW-1:0]    dest_port_i   = '0;
  logic [pha_pkg::HeaderW-1:0]  header_word_i = '0;
  logic                         out_ready_i   = 1'b0;
  logic                         cfg_valid_i   = 1'b0;
  logic [pha_pkg::CfgIdxW-1:0]  cfg_index_i   = pha_pkg::CfgListenPort;
  logic [pha_pkg::CfgDataW-1:0] cfg_data_i    = '0;

  logic                         in_ready_o;
  logic                         out_valid_o;
  logic [pha_pkg::ActW-1:0]     action_o;
  logic [pha_pkg::ChanW-1:0]    reordered_channel_o;
  logic [pha_pkg::OffW-1:0]     write_offset_o;
  logic [pha_pkg::SeqW-1:0]     write_heap_o;
  logic                         heap_closed_o;
  logic [pha_pkg::TimeW-1:0]    closed_time_o;
  logic [pha_pkg::CountW-1:0]   closed_count_o;
  logic                         closed_short_o;
  logic                         cfg_ready_o;

  int n_fail;
  int n_pending;
  int n_closed;

  // Stimulus-side view of the heap being filled.
  bit                        quiet = 1'b0;
  logic [pha_pkg::PortW-1:0] listen;
  int                        heap_size;
  logic [pha_pkg::TimeW-1:0] cur_time;
  int                        sent_in_heap;
  int                        n_sent;
  int                        n_settings;

  packet_heap_assembler u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .dest_port_i, .header_word_i,
    .out_valid_o, .out_ready_i, .action_o, .reordered_channel_o, .write_offset_o,
    .write_heap_o, .heap_closed_o, .closed_time_o, .closed_count_o, .closed_short_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  pha_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .dest_port_i, .header_word_i,
    .out_valid_i(out_valid_o), .out_ready_i, .action_i(action_o),
    .reordered_channel_i(reordered_channel_o), .write_offset_i(write_offset_o),
    .write_heap_i(write_heap_o), .heap_closed_i(heap_closed_o),
    .closed_time_i(closed_time_o), .closed_count_i(closed_count_o),
    .closed_short_i(closed_short_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .n_fail_o(n_fail), .n_pending_o(n_pending), .n_closed_o(n_closed)
  );

  always #6 clk_i = ~clk_i;

  // Result side stalls with a chance of about one in five, except in the quiet phase.
  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(0, 99) >= 20);
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", n_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [pha_pkg::HeaderW-1:0] make_header(
      input logic [pha_pkg::TimeW-1:0] t,
      input logic [pha_pkg::ChanW-1:0] ch);
    return {t, ch, 16'($urandom)};
  endfunction

  // Presents one packet beat, with an optional gap, and waits for its acceptance.
  task automatic send_packet(input logic [pha_pkg::PortW-1:0] port,
                             input logic [pha_pkg::HeaderW-1:0] hdr);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 20) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    dest_port_i   <= port;
    header_word_i <= hdr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic write_reg(input pha_pkg::cfg_idx_e idx,
                           input logic [pha_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Writes all four registers and notes what the stimulus needs of them.
  task automatic configure(input logic [pha_pkg::PortW-1:0] port,
                           input logic [pha_pkg::AntW-1:0] ant,
                           input logic [pha_pkg::SampW-1:0] samp,
                           input logic [pha_pkg::CountW-1:0] pph);
    write_reg(pha_pkg::CfgListenPort, port);
    write_reg(pha_pkg::CfgAntennas, pha_pkg::CfgDataW'(ant));
    write_reg(pha_pkg::CfgSamples, pha_pkg::CfgDataW'(samp));
    write_reg(pha_pkg::CfgPktsPerHeap, pha_pkg::CfgDataW'(pph));
    cfg_valid_i <= 1'b0;
    listen     = port;
    heap_size  = (pph == 0) ? 1 : ((pph > 1024) ? 1024 : int'(pph));
    n_settings++;
  endtask

  // Stops input and lets every outstanding result drain.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (n_pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Mostly in-order packets of the current heap, with losses, late and stray beats.
  task automatic random_packet();
    int                          r;
    logic [pha_pkg::PortW-1:0]   port;
    logic [pha_pkg::TimeW-1:0]   t;
    logic [pha_pkg::HeaderW-1:0] hdr;
    r    = $urandom_range(0, 99);
    port = listen;
    t    = cur_time;
    if (r < 6) begin
      port = listen ^ 16'($urandom_range(1, 65535));
    end else if (r < 13) begin
      t = (cur_time > 64) ? cur_time - 38'($urandom_range(1, 64)) : '0;
    end else if (r < 19) begin
      cur_time     = cur_time + 38'($urandom_range(1, 4));
      t            = cur_time;
      sent_in_heap = 0;
    end else if (r < 21) begin
      t = '0;
    end
    hdr = (r >= 21 && r < 23) ? {$urandom, $urandom} : make_header(t, 10'($urandom));
    if (r >= 13 && r < 19 || r >= 23) begin
      sent_in_heap++;
      if (sent_in_heap >= heap_size) begin
        cur_time     = cur_time + 1'b1;
        sent_in_heap = 0;
      end
    end
    send_packet(port, hdr);
  endtask

  initial begin
    logic [pha_pkg::TimeW-1:0] tmax;
    tmax       = '1;
    n_sent     = 0;
    n_settings = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: port filter, completion, time zero, late, loss and extremes.
    configure(16'hFFFF, pha_pkg::AntW'(256), pha_pkg::SampW'(4096), pha_pkg::CountW'(3));
    send_packet(16'h0000, '0);
    send_packet(16'hFFFF, make_header(38'd5, 10'd0));
    send_packet(16'hFFFF, make_header(38'd5, 10'd1023));
    send_packet(16'hFFFF, make_header(38'd5, 10'd1));
    send_packet(16'hFFFF, make_header(38'd0, 10'd2));
    send_packet(16'hFFFF, make_header(38'd0, 10'd3));
    send_packet(16'hFFFF, make_header(38'd7, 10'd4));
    send_packet(16'hFFFF, make_header(38'd7, 10'd5));
    send_packet(16'hFFFF, make_header(38'd6, 10'd6));
    send_packet(16'hFFFF, make_header(38'd0, 10'd7));
    send_packet(16'hFFFF, make_header(tmax, 10'd8));
    send_packet(16'hFFFF, make_header(tmax - 1'b1, 10'd9));
    send_packet(16'hFFFF, '1);
    send_packet(16'hFFFF, make_header(tmax, 10'd512));
    send_packet(16'h7FFF, {$urandom, $urandom});
    send_packet(16'hFFFF, make_header(tmax, 10'd511));

    // Random phases under different register settings.
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0: configure(16'($urandom), pha_pkg::AntW'(1), pha_pkg::SampW'(1),
                     pha_pkg::CountW'(1));
        1: configure(16'h0000, pha_pkg::AntW'(256), pha_pkg::SampW'(4096),
                     pha_pkg::CountW'(4));
        2: configure(16'hFFFF, pha_pkg::AntW'(511), pha_pkg::SampW'(8191),
                     pha_pkg::CountW'(0));
        3: configure(16'($urandom), pha_pkg::AntW'($urandom_range(1, 256)),
                     pha_pkg::SampW'($urandom_range(1, 4096)),
                     pha_pkg::CountW'($urandom_range(2, 16)));
        4: configure(16'($urandom), pha_pkg::AntW'(0), pha_pkg::SampW'(0),
                     pha_pkg::CountW'(2047));
        5: configure(16'($urandom), pha_pkg::AntW'($urandom_range(1, 256)),
                     pha_pkg::SampW'($urandom_range(1, 4096)), pha_pkg::CountW'(1024));
        6: configure(16'($urandom), pha_pkg::AntW'($urandom_range(1, 256)),
                     pha_pkg::SampW'($urandom_range(1, 4096)), pha_pkg::CountW'(8));
        default: configure(16'($urandom), pha_pkg::AntW'(1), pha_pkg::SampW'(4096),
                           pha_pkg::CountW'($urandom_range(1, 32)));
      endcase
      quiet        = (p == 3);
      cur_time     = {6'($urandom), 32'($urandom)};
      if (cur_time > 38'h3F_FFFF_0000) cur_time = cur_time - 38'h1_0000;
      if (cur_time == '0) cur_time = 38'd1;
      sent_in_heap = 0;
      for (int i = 0; i < PhaseItems; i++) random_packet();
    end
    quiet = 1'b0;
    drain();

    $display("Sent %0d packets under %0d register settings; %0d heaps were closed.",
             n_sent, n_settings, n_closed);
    if (n_fail == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches found", n_fail);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
